// ===== sv/dsq_pkg.sv =====
// shared types and constants for the dual square sound unit
package dsq_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  localparam logic [4:0] OFF_NR10 = 5'h00;
  localparam logic [4:0] OFF_NR11 = 5'h01;
  localparam logic [4:0] OFF_NR14 = 5'h04;
  localparam logic [4:0] OFF_NR21 = 5'h06;
  localparam logic [4:0] OFF_NR24 = 5'h09;
  localparam logic [4:0] OFF_NR50 = 5'h14;
  localparam logic [4:0] OFF_NR51 = 5'h15;
  localparam logic [4:0] OFF_NR52 = 5'h16;

  // per-channel register slots
  localparam logic [1:0] SLOT_LEN  = 2'd0;
  localparam logic [1:0] SLOT_ENV  = 2'd1;
  localparam logic [1:0] SLOT_FLO  = 2'd2;
  localparam logic [1:0] SLOT_FHI  = 2'd3;

  // one square channel's running state
  typedef struct packed {
    logic [15:0] timer;
    logic [7:0]  duty;
    logic [5:0]  len;
    logic [3:0]  vol;
    logic [7:0]  env;
    logic        dac;
  } chan_t;

  // tick strobes from the frame counter
  typedef struct packed {
    logic timer_run;
    logic len_run;
    logic env_run;
  } strobe_t;

  function automatic logic [7:0] duty_lut(input logic [1:0] sel);
    unique case (sel)
      2'd0: duty_lut = 8'h01;
      2'd1: duty_lut = 8'h81;
      2'd2: duty_lut = 8'h87;
      default: duty_lut = 8'h7E;
    endcase
  endfunction

  function automatic logic [15:0] timer_reload(input logic [7:0] lo, input logic [7:0] hi);
    logic [10:0] f;
    f = {hi[2:0], lo};
    timer_reload = {5'd0, 11'(11'd0 - f)};
  endfunction

endpackage

// ===== sv/dual_square_sound_unit.sv =====
// top level of the dual square sound unit
//   channel | valid   | stall   | payload
//   request | valid_i | stall_o | req_type_i, reg_offset_i, write_data_i
//   result  | valid_o | stall_i | read_data_o .. second_level_o
// one request is taken per cycle while stall_o is low; its result is registered and shows the next cycle
// the whole update is combinational between the request and the result register
// stall_o is high only while a result waits and stall_i holds it
// reset clears all sound state and valid_o; the result payload register is not reset
module dual_square_sound_unit import dsq_pkg::*; #(
  parameter int SAMPLE_PERIOD   = 95,
  parameter int TIMER_DIVIDE    = 4,
  parameter int LENGTH_PERIOD   = 16384,
  parameter int ENV_PERIOD      = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [4:0]        reg_offset_i,
  input  logic [7:0]        write_data_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [7:0]        read_data_o,
  output logic              sample_valid_o,
  output logic [7:0]        right_sample_o,
  output logic [7:0]        left_sample_o,
  output logic signed [8:0] right_mix_o,
  output logic signed [8:0] left_mix_o,
  output logic [3:0]        first_level_o,
  output logic [3:0]        second_level_o
);

  localparam int SW = $clog2(SAMPLE_PERIOD + 1);

  logic [15:0]   cyc_q;
  logic [SW-1:0] smp_q;
  logic [7:0]    regs_q [8];
  logic [7:0]    regs_d [8];
  logic [7:0]    sweep_q, mvol_q, route_q, pwr_q;
  logic [7:0]    sweep_d, mvol_d, route_d, pwr_d;
  chan_t         ch_q [2];
  chan_t         ch_d [2];
  logic [1:0]    on_n;
  strobe_t       stb;
  logic          acc, tick, wr, rd;
  logic          w0, w1;
  logic [1:0]    slot0, slot1;
  logic [7:0]    rdat;
  logic [3:0]    lev0, lev1;
  logic signed [8:0] rmix, lmix;
  logic [7:0]    rs, ls;

  assign stall_o = valid_o & stall_i;
  assign acc  = valid_i & ~stall_o;
  assign tick = acc && req_e'(req_type_i) == REQ_TICK;
  assign wr   = acc && req_e'(req_type_i) == REQ_WRITE;
  assign rd   = acc && req_e'(req_type_i) == REQ_READ;

  // frame counter divides
  assign stb.timer_run = (cyc_q % 16'(TIMER_DIVIDE)) == 16'd0;
  assign stb.len_run   = (32'(cyc_q) % LENGTH_PERIOD) == 0;
  assign stb.env_run   = (32'(cyc_q) % ENV_PERIOD) == 0;

  assign w0 = wr && reg_offset_i >= OFF_NR11 && reg_offset_i <= OFF_NR14;
  assign w1 = wr && reg_offset_i >= OFF_NR21 && reg_offset_i <= OFF_NR24;
  assign slot0 = 2'(reg_offset_i - OFF_NR11);
  assign slot1 = 2'(reg_offset_i - OFF_NR21);

  logic pwr_up;
  assign pwr_up = wr && reg_offset_i == OFF_NR52 && write_data_i[7];

  // each channel takes its own on flag from pwr_q; the on flags do not chain between channels
  logic on0, on1;
  dsq_channel u_ch0 (
    .cur_i(ch_q[0]), .r_len_i(regs_q[0]), .r_env_i(regs_q[1]),
    .r_flo_i(regs_q[2]), .r_fhi_i(regs_q[3]), .on_i(pwr_q[0]), .stb_i(stb),
    .tick_i(tick), .wr_i(w0), .slot_i(slot0), .data_i(write_data_i),
    .pwr_on_i(pwr_up), .nxt_o(ch_d[0]), .on_o(on0)
  );
  dsq_channel u_ch1 (
    .cur_i(ch_q[1]), .r_len_i(regs_q[4]), .r_env_i(regs_q[5]),
    .r_flo_i(regs_q[6]), .r_fhi_i(regs_q[7]), .on_i(pwr_q[1]), .stb_i(stb),
    .tick_i(tick), .wr_i(w1), .slot_i(slot1), .data_i(write_data_i),
    .pwr_on_i(pwr_up), .nxt_o(ch_d[1]), .on_o(on1)
  );
  assign on_n = {on1, on0};

  // register file update
  always_comb begin
    regs_d  = regs_q;
    sweep_d = sweep_q;
    mvol_d  = mvol_q;
    route_d = route_q;
    pwr_d   = {pwr_q[7:2], on_n};
    rdat    = 8'd0;
    if (w0) regs_d[3'(slot0)] = write_data_i;
    if (w1) regs_d[3'({1'b1, slot1})] = write_data_i;
    if (wr) begin
      priority case (reg_offset_i)
        OFF_NR10: sweep_d = write_data_i;
        OFF_NR50: mvol_d  = write_data_i;
        OFF_NR51: route_d = write_data_i;
        OFF_NR52: begin
          pwr_d = {write_data_i[7], 7'd0};
          if (!write_data_i[7]) begin
            for (int i = 0; i < 8; i++) regs_d[i] = 8'd0;
            sweep_d = 8'd0;
            mvol_d  = 8'd0;
            route_d = 8'd0;
          end
        end
        default: ;
      endcase
    end
    if (rd) begin
      priority if (reg_offset_i == OFF_NR10) rdat = sweep_q;
      else if (reg_offset_i >= OFF_NR11 && reg_offset_i <= OFF_NR14) rdat = regs_q[3'(slot0)];
      else if (reg_offset_i >= OFF_NR21 && reg_offset_i <= OFF_NR24)
        rdat = regs_q[3'({1'b1, slot1})];
      else if (reg_offset_i == OFF_NR50) rdat = mvol_q;
      else if (reg_offset_i == OFF_NR51) rdat = route_q;
      else if (reg_offset_i == OFF_NR52) rdat = pwr_q;
      else rdat = 8'd0;
    end
  end

  // mix uses the state after this request
  dsq_mixer u_mix (
    .on_i(pwr_d[1:0]), .duty0_i({ch_d[1].duty[0], ch_d[0].duty[0]}),
    .vol0_i(ch_d[0].vol), .vol1_i(ch_d[1].vol), .dac_i({ch_d[1].dac, ch_d[0].dac}),
    .route_i(route_d), .mvol_i(mvol_d), .lev0_o(lev0), .lev1_o(lev1),
    .rmix_o(rmix), .lmix_o(lmix), .rs_o(rs), .ls_o(ls)
  );

  logic smp_hit;
  assign smp_hit = tick && smp_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q   <= '0;
      smp_q   <= '0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      sweep_q <= '0;
      mvol_q  <= '0;
      route_q <= '0;
      pwr_q   <= '0;
      ch_q[0] <= '0;
      ch_q[1] <= '0;
      valid_o <= 1'b0;
    end else begin
      if (acc) begin
        regs_q  <= regs_d;
        sweep_q <= sweep_d;
        mvol_q  <= mvol_d;
        route_q <= route_d;
        pwr_q   <= pwr_d;
        ch_q[0] <= ch_d[0];
        ch_q[1] <= ch_d[1];
      end
      if (pwr_up) begin
        cyc_q <= '0;
        smp_q <= '0;
      end else if (tick) begin
        cyc_q <= cyc_q + 16'd1;
        smp_q <= (smp_q == SW'(SAMPLE_PERIOD - 1)) ? '0 : smp_q + SW'(1);
      end
      if (acc) valid_o <= 1'b1;
      else if (!stall_i) valid_o <= 1'b0;
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (acc) begin
      read_data_o    <= rdat;
      sample_valid_o <= smp_hit;
      right_sample_o <= smp_hit ? rs : 8'd0;
      left_sample_o  <= smp_hit ? ls : 8'd0;
      right_mix_o    <= rmix;
      left_mix_o     <= lmix;
      first_level_o  <= lev0;
      second_level_o <= lev1;
    end
  end

`ifndef ASSERT_OFF
  a_smp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_q < SW'(SAMPLE_PERIOD)) else $error("sample counter out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(read_data_o) && valid_o) else $error("result changed while stalled");
  a_sv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !sample_valid_o |-> right_sample_o == 8'd0 && left_sample_o == 8'd0)
    else $error("sample bytes without sample");
`endif

endmodule

// ===== sv/dsq_channel.sv =====
// one square channel: timer, duty rotation, length counter and envelope
module dsq_channel import dsq_pkg::*; (
  input  chan_t        cur_i,
  input  logic [7:0]   r_len_i,
  input  logic [7:0]   r_env_i,
  input  logic [7:0]   r_flo_i,
  input  logic [7:0]   r_fhi_i,
  input  logic         on_i,
  input  strobe_t      stb_i,
  input  logic         tick_i,
  input  logic         wr_i,
  input  logic [1:0]   slot_i,
  input  logic [7:0]   data_i,
  input  logic         pwr_on_i,
  output chan_t        nxt_o,
  output logic         on_o
);

  logic [15:0] t;
  logic [7:0]  e;

  always_comb begin
    nxt_o = cur_i;
    on_o  = on_i;
    t     = '0;
    e     = '0;
    if (tick_i) begin
      if (stb_i.timer_run) begin
        t = cur_i.timer - 16'd1;
        if (t == 16'd0) nxt_o.duty = {cur_i.duty[6:0], cur_i.duty[7]};
        else if (t == 16'hFFFF) t = timer_reload(r_flo_i, r_fhi_i);
        nxt_o.timer = t;
      end
      if (stb_i.len_run && r_fhi_i[6] && cur_i.len != 6'd0) begin
        nxt_o.len = cur_i.len - 6'd1;
        if (cur_i.len == 6'd1) on_o = 1'b0;
      end
      if (stb_i.env_run && r_env_i[2:0] != 3'd0) begin
        e = cur_i.env - 8'd1;
        if (e == 8'd0) begin
          if (r_env_i[3]) begin
            if (cur_i.vol != 4'd15) nxt_o.vol = cur_i.vol + 4'd1;
          end else if (cur_i.vol != 4'd0) begin
            nxt_o.vol = cur_i.vol - 4'd1;
          end
        end else if (e == 8'hFF) begin
          e = {5'd0, r_env_i[2:0]};
        end
        nxt_o.env = e;
      end
    end else if (wr_i) begin
      unique case (slot_i)
        SLOT_LEN: begin
          nxt_o.len  = 6'd0 - data_i[5:0];
          nxt_o.duty = duty_lut(data_i[7:6]);
        end
        SLOT_ENV: begin
          nxt_o.vol = data_i[7:4];
          nxt_o.env = {5'd0, data_i[2:0]};
          nxt_o.dac = (data_i[7:4] != 4'd0);
          if (data_i[7:4] == 4'd0) on_o = 1'b0;
        end
        SLOT_FLO: begin
          nxt_o.timer = timer_reload(data_i, r_fhi_i);
        end
        default: begin
          nxt_o.timer = timer_reload(r_flo_i, data_i);
          if (data_i[7]) begin
            if (cur_i.len == 6'd0) nxt_o.len = 6'd63;
            nxt_o.vol = r_env_i[7:4];
            nxt_o.env = {5'd0, r_env_i[2:0]};
            on_o = cur_i.dac;
          end
        end
      endcase
    end else if (pwr_on_i) begin
      nxt_o.duty = duty_lut(r_len_i[7:6]);
    end
  end

endmodule

// ===== sv/dsq_mixer.sv =====
// stereo mix, volume scaling and sample byte conversion
module dsq_mixer import dsq_pkg::*; (
  input  logic [1:0]        on_i,
  input  logic [1:0]        duty0_i,
  input  logic [3:0]        vol0_i,
  input  logic [3:0]        vol1_i,
  input  logic [1:0]        dac_i,
  input  logic [7:0]        route_i,
  input  logic [7:0]        mvol_i,
  output logic [3:0]        lev0_o,
  output logic [3:0]        lev1_o,
  output logic signed [8:0] rmix_o,
  output logic signed [8:0] lmix_o,
  output logic [7:0]        rs_o,
  output logic [7:0]        ls_o
);

  logic signed [5:0] d0, d1, rsum, lsum;
  logic [14:0] rx, lx;

  always_comb begin
    lev0_o = (on_i[0] && duty0_i[0]) ? vol0_i : 4'd0;
    lev1_o = (on_i[1] && duty0_i[1]) ? vol1_i : 4'd0;
    d0 = dac_i[0] ? 6'sd2 * $signed({2'b0, lev0_o}) - 6'sd15 : 6'sd0;
    d1 = dac_i[1] ? 6'sd2 * $signed({2'b0, lev1_o}) - 6'sd15 : 6'sd0;
    rsum = (route_i[0] ? d0 : 6'sd0) + (route_i[1] ? d1 : 6'sd0);
    lsum = (route_i[4] ? d0 : 6'sd0) + (route_i[5] ? d1 : 6'sd0);
    rmix_o = 9'(rsum * $signed({6'd0, mvol_i[2:0]} + 9'sd1));
    lmix_o = 9'(lsum * $signed({6'd0, mvol_i[6:4]} + 9'sd1));
    // offset level is 240..720, taken as unsigned
    rx = {5'd0, 10'(rmix_o + 10'sd480)} * 15'd17;
    lx = {5'd0, 10'(lmix_o + 10'sd480)} * 15'd17;
    rs_o = rx[13:6];
    ls_o = lx[13:6];
  end

endmodule
